/* hw/rtl/lcr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Load-cell reader package
// Shared widths, register indexes and the status bundle of the iterative divider.
// ----------------------------------------------------------------------------
package lcr_pkg;

    // Converter word and weight format.
    localparam int SAMPLE_BITS    = 24;
    localparam int GRAM_FRAC_BITS = 8;
    localparam int GRAMS_WIDTH    = 32;

    // The scale register carries 8 fraction bits of its own.
    localparam int SCALE_FRAC_BITS = 8;
    localparam int DIVISOR_WIDTH   = 32;

    // Dividend is the magnitude shifted up by both fraction widths.
    localparam int DIV_WIDTH = SAMPLE_BITS + GRAM_FRAC_BITS + SCALE_FRAC_BITS;
    localparam int STEP_W    = $clog2(DIV_WIDTH + 1);

    // Register indexes of the configuration channel.
    localparam logic [1:0] CFG_RAW_OFFSET    = 2'd0;
    localparam logic [1:0] CFG_SCALE_Q8      = 2'd1;
    localparam logic [1:0] CFG_READY_TIMEOUT = 2'd2;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage
`default_nettype wire

/* hw/rtl/lcr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Load-cell reader divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcr_div
    import lcr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIV_WIDTH-1:0]     dividend,
    input  wire logic [DIVISOR_WIDTH-1:0] divisor,
    output logic      [DIV_WIDTH-1:0]     quotient,
    output div_status_t                   status
);

    logic [DIV_WIDTH-1:0]     dq_reg;
    logic [DIV_WIDTH-1:0]     dq_next;
    logic [DIVISOR_WIDTH-1:0] rem_reg;
    logic [DIVISOR_WIDTH-1:0] rem_next;
    logic [DIVISOR_WIDTH-1:0] dvs_reg;
    logic [STEP_W-1:0]        cnt_reg;
    logic                     done_reg;

    logic [DIVISOR_WIDTH:0]   trial;
    logic [DIVISOR_WIDTH+1:0] diff;
    logic                     fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    // A zero divisor always fits, which yields an all-ones quotient.
    always_comb
    begin
        trial    = {rem_reg, dq_reg[DIV_WIDTH-1]};
        diff     = {1'b0, trial} - {2'b00, dvs_reg};
        fits     = ~diff[DIVISOR_WIDTH+1];
        rem_next = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
        dq_next  = {dq_reg[DIV_WIDTH-2:0], fits};
    end

    // Step counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == STEP_W'(1));
            if (start)
            begin
                cnt_reg <= STEP_W'(DIV_WIDTH);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= STEP_W'(cnt_reg - 1'b1);
            end
        end
    end

    // Datapath: the dividend shifts out of the quotient register as bits enter.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            dq_reg  <= dq_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = dq_reg;
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule
`default_nettype wire

/* hw/rtl/load_cell_adc_serial_reader.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Load-cell converter serial reader
// Bit-bangs a 24-bit bridge converter one tick per input beat and scales the
// finished sample to signed Q8 grams.
// ----------------------------------------------------------------------------
// Each input beat is one timing tick and produces exactly one output beat
// carrying the clock level to drive for that tick. For an ordinary tick the
// result is registered and the next tick is taken as soon as the output
// register is free. A tick that ends a reading (the final low tick of the
// gain-select pulse, or a ready timeout) starts the shared restoring divider,
// which produces one quotient bit per cycle over 40 bits; in_stall stays high
// until that tick's result is registered, so no new tick is taken while the
// division is under way. Configuration writes are always taken (cfg_ready is
// tied high) and must only be issued while no reading result is outstanding.
module load_cell_adc_serial_reader
    import lcr_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Tick input channel.
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          request,
    input  wire logic                          data_level,
    // Result output channel.
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               sck_level,
    output logic                               busy_res,
    output logic                               done_res,
    output logic                               timed_out,
    output logic        [SAMPLE_BITS-1:0]      raw_count,
    output logic signed [GRAMS_WIDTH-1:0]      grams_q8,
    // Configuration write channel.
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic   [1:0]                  cfg_index,
    input  wire logic   [DIVISOR_WIDTH-1:0]    cfg_data
);

    localparam int TIMEOUT_W = 20;
    localparam int BIT_W     = $clog2(SAMPLE_BITS + 1);

    localparam logic [SAMPLE_BITS-1:0]   OFFSET_RESET  = '0;
    localparam logic [DIVISOR_WIDTH-1:0] SCALE_RESET   = DIVISOR_WIDTH'(256);
    localparam logic [TIMEOUT_W-1:0]     TIMEOUT_RESET = TIMEOUT_W'(200000);

    localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [GRAMS_WIDTH-1:0] GRAMS_MAX = {1'b0, {(GRAMS_WIDTH-1){1'b1}}};
    localparam logic [GRAMS_WIDTH-1:0] GRAMS_MIN = {1'b1, {(GRAMS_WIDTH-1){1'b0}}};
    localparam int SHIFT_BITS = GRAM_FRAC_BITS + SCALE_FRAC_BITS;

    // Bus phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAIT  = 3'd1;
    localparam logic [2:0] PH_HIGH  = 3'd2;
    localparam logic [2:0] PH_LOW   = 3'd3;
    localparam logic [2:0] PH_XHIGH = 3'd4;
    localparam logic [2:0] PH_XLOW  = 3'd5;

    // Configuration registers.
    logic [SAMPLE_BITS-1:0]   raw_offset_reg;
    logic [DIVISOR_WIDTH-1:0] scale_q8_reg;
    logic [TIMEOUT_W-1:0]     ready_timeout_reg;

    // Sequencer state.
    logic [2:0]               phase_reg;
    logic [2:0]               phase_next;
    logic [TIMEOUT_W-1:0]     wait_count_reg;
    logic [TIMEOUT_W-1:0]     wait_count_next;
    logic [BIT_W-1:0]         bit_index_reg;
    logic [BIT_W-1:0]         bit_index_next;
    logic [SAMPLE_BITS-1:0]   shift_word_reg;
    logic [SAMPLE_BITS-1:0]   shift_word_next;
    logic [GRAMS_WIDTH-1:0]   last_grams_reg;
    logic                     wait_div_reg;
    logic                     neg_reg;
    logic                     mag_zero_reg;

    // Output register.
    logic                     out_valid_reg;
    logic                     sck_level_reg;
    logic                     busy_res_reg;
    logic                     done_res_reg;
    logic                     timed_out_reg;
    logic [SAMPLE_BITS-1:0]   raw_count_reg;

    // Per-tick results.
    logic                     tick_sck;
    logic                     tick_busy;
    logic                     tick_done;
    logic                     tick_tmo;
    logic [SAMPLE_BITS-1:0]   tick_raw;

    logic                     in_accept;
    logic                     div_start;
    logic [SAMPLE_BITS:0]     diff;
    logic                     diff_neg;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [DIV_WIDTH-1:0]     dividend;
    logic [DIV_WIDTH-1:0]     quotient;
    div_status_t              div_stat;
    logic                     q_big;
    logic [GRAMS_WIDTH-1:0]   grams_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = wait_div_reg | (out_valid_reg & out_stall);
    assign in_accept = in_valid & ~in_stall;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_offset_reg    <= OFFSET_RESET;
            scale_q8_reg      <= SCALE_RESET;
            ready_timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RAW_OFFSET:    raw_offset_reg    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_SCALE_Q8:      scale_q8_reg      <= cfg_data;
                CFG_READY_TIMEOUT: ready_timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default:           ;
            endcase
        end
    end

    // Tick sequencer: clock level, wait countdown and bit capture.
    always_comb
    begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        bit_index_next  = bit_index_reg;
        shift_word_next = shift_word_reg;
        tick_sck        = 1'b0;
        tick_busy       = 1'b1;
        tick_done       = 1'b0;
        tick_tmo        = 1'b0;
        tick_raw        = '0;
        case (phase_reg)
            PH_IDLE:
            begin
                tick_busy = 1'b0;
                if (request)
                begin
                    tick_busy       = 1'b1;
                    wait_count_next = ready_timeout_reg;
                    phase_next      = PH_WAIT;
                end
            end
            PH_WAIT:
            begin
                if (!data_level)
                begin
                    bit_index_next  = '0;
                    shift_word_next = '0;
                    phase_next      = PH_HIGH;
                end
                else if (wait_count_reg <= TIMEOUT_W'(1))
                begin
                    // Converter never came ready: finish with raw zero.
                    wait_count_next = '0;
                    tick_done       = 1'b1;
                    tick_tmo        = 1'b1;
                    tick_busy       = 1'b0;
                    phase_next      = PH_IDLE;
                end
                else
                begin
                    wait_count_next = TIMEOUT_W'(wait_count_reg - 1'b1);
                end
            end
            PH_HIGH:
            begin
                tick_sck   = 1'b1;
                phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                shift_word_next = {shift_word_reg[SAMPLE_BITS-2:0], data_level};
                bit_index_next  = BIT_W'(bit_index_reg + 1'b1);
                phase_next      = (bit_index_next >= BIT_W'(SAMPLE_BITS)) ? PH_XHIGH
                                                                          : PH_HIGH;
            end
            PH_XHIGH:
            begin
                tick_sck   = 1'b1;
                phase_next = PH_XLOW;
            end
            default:
            begin
                // Low half of the gain-select pulse ends the reading.
                tick_raw   = shift_word_reg ^ SIGN_FLIP;
                tick_done  = 1'b1;
                tick_busy  = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Signed difference against the tare offset, taken apart into sign and size.
    always_comb
    begin
        diff     = {1'b0, tick_raw} - {1'b0, raw_offset_reg};
        diff_neg = diff[SAMPLE_BITS];
        mag      = diff_neg ? SAMPLE_BITS'(-diff) : diff[SAMPLE_BITS-1:0];
        dividend = {mag, {SHIFT_BITS{1'b0}}};
    end

    assign div_start = in_accept & tick_done;

    lcr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (scale_q8_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    // Saturate the quotient to the signed weight range and apply the sign.
    // A zero difference weighs zero even when the scale is zero.
    always_comb
    begin
        q_big = |quotient[DIV_WIDTH-1:GRAMS_WIDTH-1];
        if (mag_zero_reg)
        begin
            grams_sat = '0;
        end
        else if (neg_reg)
        begin
            grams_sat = q_big ? GRAMS_MIN : GRAMS_WIDTH'(-quotient[GRAMS_WIDTH-1:0]);
        end
        else
        begin
            grams_sat = q_big ? GRAMS_MAX : quotient[GRAMS_WIDTH-1:0];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            wait_count_reg <= '0;
            bit_index_reg  <= '0;
            shift_word_reg <= '0;
            last_grams_reg <= '0;
            wait_div_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg      <= phase_next;
                wait_count_reg <= wait_count_next;
                bit_index_reg  <= bit_index_next;
                shift_word_reg <= shift_word_next;
            end

            if (div_stat.done)
            begin
                last_grams_reg <= grams_sat;
            end

            if (div_start)
            begin
                wait_div_reg <= 1'b1;
            end
            else if (div_stat.done)
            begin
                wait_div_reg <= 1'b0;
            end

            // A result is shown at once for ordinary ticks, after division otherwise.
            if ((in_accept && !tick_done) || div_stat.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload and the sign held across the division.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sck_level_reg <= tick_sck;
            busy_res_reg  <= tick_busy;
            done_res_reg  <= tick_done;
            timed_out_reg <= tick_tmo;
            raw_count_reg <= tick_raw;
            neg_reg       <= diff_neg;
            mag_zero_reg  <= (mag == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign sck_level = sck_level_reg;
    assign busy_res  = busy_res_reg;
    assign done_res  = done_res_reg;
    assign timed_out = timed_out_reg;
    assign raw_count = raw_count_reg;
    assign grams_q8  = last_grams_reg;

    // The divider only finishes for a reading that is waiting on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> wait_div_reg)
        else $error("divider finished with no reading pending");

    // A finished division shows a done beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |=> (out_valid_reg && done_res_reg))
        else $error("division result not presented as a done beat");

    // A done beat never reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_res_reg) |-> !busy_res_reg)
        else $error("done beat flagged busy");

    // A timeout carries a zero raw count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && timed_out_reg) |-> (done_res_reg && (raw_count_reg == '0)))
        else $error("timeout beat with raw data");

    // The clock line is only driven high during a reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sck_level_reg) |-> busy_res_reg)
        else $error("clock high outside a reading");

endmodule
`default_nettype wire
